// ===== design/lru_page_replacement_top_defines.svh =====
// assertion helpers for the block's top module
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LRUPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru page replacement check failed");

// next-cycle implication, checked out of reset
`define LRUPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru page replacement check failed");

`endif

// ===== design/lrupr_pkg.sv =====
package lrupr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int PAGE_W     = 8;
    localparam int FAULT_W    = 16;
    localparam int FRAMES_W   = 4;
    localparam int OCC_W      = 4;

    localparam logic [FAULT_W-1:0]  FAULT_MAX    = '1;
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [PAGE_W-1:0] wr_data;
    } t_stk_ctrl;

endpackage

// ===== design/lrupr_stack.sv =====
module lrupr_stack
    import lrupr_pkg::*;
(
    input  logic              i_clk,
    input  t_stk_ctrl         i_ctrl,
    input  logic [PAGE_W-1:0] i_page,
    output logic [PAGE_W-1:0] o_rd_data,
    output logic              o_match
);

    // recency order: slot 0 least recent
    logic [PAGE_W-1:0] r_slot [MAX_FRAMES];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_slot[i_ctrl.wr_addr] <= i_ctrl.wr_data;
        end
    end

    assign o_rd_data = r_slot[i_ctrl.rd_addr];
    // the one comparator, reused once per scanned slot
    assign o_match   = (o_rd_data == i_page);

endmodule

// ===== design/lru_page_replacement_top.sv =====
// a reference goes from accept to result through scan, shift and done states:
// a scan visits one stack slot per cycle through the single comparator; on a hit or an
// eviction the stack then closes the gap one slot per cycle; the result is then registered.
// the next reference is taken once the result is loaded, which waits while the output stalls.
// reset (i_rst_n low, synchronous) empties the stack, clears the fault count and
// sets frames in use to 8; stack contents are not cleared.
`include "lru_page_replacement_top_defines.svh"

module lru_page_replacement_top
    import lrupr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [FRAMES_W-1:0] i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [PAGE_W-1:0]   i_page,
    input  logic                i_restart,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_hit,
    output logic [FAULT_W-1:0]  o_fault_number,
    output logic                o_evicted_valid,
    output logic [PAGE_W-1:0]   o_evicted_page,
    output logic [OCC_W-1:0]    o_occupied
);

    t_state              r_state, n_state;
    logic [FRAMES_W-1:0] r_frames;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [FAULT_W-1:0]  r_fault, n_fault;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [PAGE_W-1:0]   r_first, n_first;
    logic                r_hit, n_hit;
    logic                r_evict, n_evict;
    logic [FAULT_W-1:0]  r_fnum, n_fnum;

    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, n_out_hit;
    logic [FAULT_W-1:0]  r_out_fnum, n_out_fnum;
    logic                r_out_evict, n_out_evict;
    logic [PAGE_W-1:0]   r_out_ev_page, n_out_ev_page;
    logic [CNT_W-1:0]    r_out_occ, n_out_occ;

    t_stk_ctrl           stk_ctrl;
    logic [PAGE_W-1:0]   stk_rd_data;
    logic                stk_match;
    logic [CNT_W-1:0]    lim;
    logic [CNT_W-1:0]    idx_p1;

    lrupr_stack u_stack (
        .i_clk     (i_clk),
        .i_ctrl    (stk_ctrl),
        .i_page    (r_page),
        .o_rd_data (stk_rd_data),
        .o_match   (stk_match)
    );

    always_comb begin
        if (r_frames == '0) begin
            lim = CNT_W'(1);
        end else if (int'(r_frames) > MAX_FRAMES) begin
            lim = CNT_W'(MAX_FRAMES);
        end else begin
            lim = CNT_W'(r_frames);
        end
    end

    assign idx_p1 = r_idx + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_frames    <= FRAMES_RESET;
            r_occ       <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_frames <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_page        <= n_page;
        r_first       <= n_first;
        r_hit         <= n_hit;
        r_evict       <= n_evict;
        r_fnum        <= n_fnum;
        r_out_hit     <= n_out_hit;
        r_out_fnum    <= n_out_fnum;
        r_out_evict   <= n_out_evict;
        r_out_ev_page <= n_out_ev_page;
        r_out_occ     <= n_out_occ;
    end

    always_comb begin
        n_state       = r_state;
        n_occ         = r_occ;
        n_idx         = r_idx;
        n_fault       = r_fault;
        n_page        = r_page;
        n_first       = r_first;
        n_hit         = r_hit;
        n_evict       = r_evict;
        n_fnum        = r_fnum;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_hit     = r_out_hit;
        n_out_fnum    = r_out_fnum;
        n_out_evict   = r_out_evict;
        n_out_ev_page = r_out_ev_page;
        n_out_occ     = r_out_occ;

        stk_ctrl.rd_addr = r_idx[IDX_W-1:0];
        stk_ctrl.wr_en   = 1'b0;
        stk_ctrl.wr_addr = r_idx[IDX_W-1:0];
        stk_ctrl.wr_data = stk_rd_data;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_page  = i_page;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_evict = 1'b0;
                    n_fnum  = '0;
                    if (i_restart) begin
                        n_occ   = '0;
                        n_fault = '0;
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == '0) begin
                    n_first = stk_rd_data;
                end
                if (r_idx == r_occ) begin
                    // miss: count the fault, then append or evict
                    n_fnum = r_fault;
                    if (r_fault != FAULT_MAX) begin
                        n_fault = r_fault + FAULT_W'(1);
                    end
                    if (r_occ < lim) begin
                        stk_ctrl.wr_en   = 1'b1;
                        stk_ctrl.wr_addr = r_occ[IDX_W-1:0];
                        stk_ctrl.wr_data = r_page;
                        n_occ            = r_occ + CNT_W'(1);
                        n_state          = ST_DONE;
                    end else begin
                        n_evict = 1'b1;
                        n_idx   = '0;
                        n_state = ST_SHIFT;
                    end
                end else if (stk_match) begin
                    n_hit   = 1'b1;
                    n_state = ST_SHIFT;
                end else begin
                    n_idx = idx_p1;
                end
            end
            ST_SHIFT: begin
                if (idx_p1 < r_occ) begin
                    stk_ctrl.rd_addr = idx_p1[IDX_W-1:0];
                    stk_ctrl.wr_en   = 1'b1;
                    n_idx            = idx_p1;
                end else begin
                    // gap reached the top: page becomes most recent
                    stk_ctrl.wr_en   = 1'b1;
                    stk_ctrl.wr_data = r_page;
                    n_state          = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_hit     = r_hit;
                    n_out_fnum    = r_fnum;
                    n_out_evict   = r_evict;
                    n_out_ev_page = r_evict ? r_first : '0;
                    n_out_occ     = r_occ;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_fault_number  = r_out_fnum;
    assign o_evicted_valid = r_out_evict;
    assign o_evicted_page  = r_out_ev_page;
    assign o_occupied      = OCC_W'(r_out_occ);

    `LRUPR_ASSERT_NOW(a_occ_bound, 1'b1, int'(r_occ) <= MAX_FRAMES)
    `LRUPR_ASSERT_NOW(a_shift_nonempty, r_state == ST_SHIFT, r_occ != '0)
    `LRUPR_ASSERT_NOW(a_evict_is_miss, o_out_valid && o_evicted_valid, !o_hit)
    `LRUPR_ASSERT_NOW(a_hit_no_fnum, o_out_valid && o_hit, o_fault_number == '0)
    `LRUPR_ASSERT_NEXT(a_done_drains, r_state == ST_DONE && !r_out_valid, o_out_valid)

endmodule
